// ===== hdl/bbsf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbsf_pkg: shared types and constants for the bounded byte stream FIFO
// Holds the store geometry, opcodes, command/result payloads and the
// memory request bundle passed from the sequencer to the top level.
// ----------------------------------------------------------------------------
package bbsf_pkg;

	localparam int DEPTH      = 1024;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = 11;
	localparam int MAX_RUN    = 64;
	localparam int RUN_W      = 7;
	localparam int TOTAL_BITS = 48;
	localparam int BYTE_W     = 8;
	localparam int OP_W       = 3;

	// APB: one 32-bit register, word 0 holds capacity
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;
	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [CNT_W-1:0] CAPACITY_RST = CNT_W'(1024);

	localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_READ  = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP   = 3'd3;
	localparam logic [OP_W-1:0] OP_END   = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [BYTE_W-1:0] data_byte;
		logic [RUN_W-1:0]  run_length;
	} bbsf_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0]     byte_out;
		logic                  byte_valid;
		logic                  last_of_run;
		logic                  write_accepted;
		logic [CNT_W-1:0]      stored_count;
		logic [CNT_W-1:0]      room_left;
		logic                  ended_flag;
		logic                  at_eof;
		logic [TOTAL_BITS-1:0] total_written;
		logic [TOTAL_BITS-1:0] total_read;
	} bbsf_res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} bbsf_mem_req_t;

endpackage
`default_nettype wire

// ===== hdl/bbsf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbsf_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bbsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/bbsf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbsf_ctrl: FIFO sequencer and status
// Keeps head, count, totals and the ended flag; steps read and peek runs
// through the byte store one address per cycle and forms each result.
// ----------------------------------------------------------------------------
module bbsf_ctrl (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire  bbsf_pkg::bbsf_cmd_t          cmd,
	input  wire  [bbsf_pkg::CNT_W-1:0]         capacity,
	output bbsf_pkg::bbsf_mem_req_t            mem_req,
	input  wire  [bbsf_pkg::BYTE_W-1:0]        mem_rdata,
	output logic                               result_valid,
	output bbsf_pkg::bbsf_res_t                result
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	localparam int AW = bbsf_pkg::ADDR_W;
	localparam int CW = bbsf_pkg::CNT_W;
	localparam int RW = bbsf_pkg::RUN_W;
	localparam int TW = bbsf_pkg::TOTAL_BITS;

	localparam logic [CW-1:0] DEPTH_CNT = CW'(bbsf_pkg::DEPTH);
	localparam logic [AW:0]   DEPTH_SUM = (AW+1)'(bbsf_pkg::DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(bbsf_pkg::DEPTH - 1);
	localparam logic [RW-1:0] RUN_MAX   = RW'(bbsf_pkg::MAX_RUN);

	logic          state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] held_q;
	logic [TW-1:0] wtot_q;
	logic [TW-1:0] rtot_q;
	logic          done_q;
	logic [AW-1:0] rd_ptr_q;
	logic [RW-1:0] remain_q;
	logic          is_read_q;
	logic          res_valid_q;
	logic          res_bytev_q;
	logic          res_last_q;
	logic          res_acc_q;

	logic          accept;
	logic          issue;
	logic [CW-1:0] limit;
	logic          has_room;
	logic [RW-1:0] run_cap;
	logic [RW-1:0] run_n;
	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic [AW:0]   pop_sum;
	logic [AW-1:0] pop_head;
	logic [AW-1:0] ptr_next;
	logic          is_run_op;

	// handshake and effective limit
	assign accept   = start && (state_q == ST_IDLE);
	assign issue    = (state_q == ST_RUN);
	assign busy     = issue;
	assign limit    = (capacity > DEPTH_CNT) ? DEPTH_CNT : capacity;
	assign has_room = (held_q < limit);

	// clip the run at the maximum and at the held count
	assign run_cap = (cmd.run_length > RUN_MAX) ? RUN_MAX : cmd.run_length;
	assign run_n   = (CW'(run_cap) > held_q) ? held_q[RW-1:0] : run_cap;

	// circular pointer arithmetic
	assign tail_sum = {1'b0, head_q} + held_q[AW:0];
	assign tail     = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : tail_sum[AW-1:0];
	assign pop_sum  = {1'b0, head_q} + (AW+1)'(run_n);
	assign pop_head = (pop_sum >= DEPTH_SUM) ? AW'(pop_sum - DEPTH_SUM) : pop_sum[AW-1:0];
	assign ptr_next = (rd_ptr_q == LAST_ADDR) ? '0 : rd_ptr_q + 1'b1;

	assign is_run_op = (cmd.opcode == bbsf_pkg::OP_READ) || (cmd.opcode == bbsf_pkg::OP_PEEK);

	// store accesses: write on an accepted byte, read one per run cycle
	always_comb begin
		mem_req.we    = accept && (cmd.opcode == bbsf_pkg::OP_WRITE) && has_room;
		mem_req.waddr = tail;
		mem_req.wdata = cmd.data_byte;
		mem_req.re    = issue;
		mem_req.raddr = rd_ptr_q;
	end

	// sequencer and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			held_q      <= '0;
			wtot_q      <= '0;
			rtot_q      <= '0;
			done_q      <= 1'b0;
			rd_ptr_q    <= '0;
			remain_q    <= '0;
			is_read_q   <= 1'b0;
			res_valid_q <= 1'b0;
			res_bytev_q <= 1'b0;
			res_last_q  <= 1'b0;
			res_acc_q   <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			res_bytev_q <= 1'b0;
			res_last_q  <= 1'b0;
			res_acc_q   <= 1'b0;
			if (accept) begin
				// single status result unless a run with bytes starts
				res_valid_q <= !(is_run_op && (run_n != '0));
				res_last_q  <= 1'b1;
				case (cmd.opcode)
					bbsf_pkg::OP_WRITE: begin
						if (has_room) begin
							held_q    <= held_q + 1'b1;
							wtot_q    <= wtot_q + 1'b1;
							res_acc_q <= 1'b1;
						end
					end
					bbsf_pkg::OP_READ, bbsf_pkg::OP_PEEK: begin
						if (run_n != '0) begin
							state_q   <= ST_RUN;
							remain_q  <= run_n;
							rd_ptr_q  <= head_q;
							is_read_q <= (cmd.opcode == bbsf_pkg::OP_READ);
						end
					end
					bbsf_pkg::OP_POP: begin
						head_q <= pop_head;
						held_q <= held_q - CW'(run_n);
						rtot_q <= rtot_q + TW'(run_n);
					end
					bbsf_pkg::OP_END: begin
						done_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end else if (issue) begin
				// advance one byte; a read also drops it from the head
				rd_ptr_q    <= ptr_next;
				remain_q    <= remain_q - 1'b1;
				res_valid_q <= 1'b1;
				res_bytev_q <= 1'b1;
				res_last_q  <= (remain_q == RW'(1));
				if (is_read_q) begin
					head_q <= ptr_next;
					held_q <= held_q - 1'b1;
					rtot_q <= rtot_q + 1'b1;
				end
				if (remain_q == RW'(1)) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	// status reflects state after the result's own effect
	always_comb begin
		result.byte_out       = res_bytev_q ? mem_rdata : '0;
		result.byte_valid     = res_bytev_q;
		result.last_of_run    = res_last_q;
		result.write_accepted = res_acc_q;
		result.stored_count   = held_q;
		result.room_left      = has_room ? limit - held_q : '0;
		result.ended_flag     = done_q;
		result.at_eof         = done_q && (held_q == '0);
		result.total_written  = wtot_q;
		result.total_read     = rtot_q;
	end

	assign result_valid = res_valid_q;

endmodule
`default_nettype wire

// ===== hdl/bounded_byte_stream_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_byte_stream_fifo: byte FIFO with capacity limit and end marking
// Write, end, pop and unknown commands, and reads or peeks of no bytes,
// give one result in the cycle after they are taken. A read or peek run
// of n bytes (n clipped at 64 and at the held count) keeps busy high while
// the store is read, as it has one read port and yields one byte per
// cycle; each result follows in the cycle after its read, the last marked
// by last_of_run. Results are strobed by result_valid for a single cycle
// and cannot be stalled. Capacity sits at APB address 0 and may only be
// changed while the block is idle. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bounded_byte_stream_fifo (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  bbsf_pkg::bbsf_cmd_t           cmd,
	output logic                                result_valid,
	output bbsf_pkg::bbsf_res_t                 result,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [bbsf_pkg::APB_AW-1:0]         paddr,
	input  wire  [bbsf_pkg::APB_DW-1:0]         pwdata,
	output logic [bbsf_pkg::APB_DW-1:0]         prdata,
	output logic                                pready
);

	logic [bbsf_pkg::CNT_W-1:0]  capacity_q;
	logic                        cap_sel;
	bbsf_pkg::bbsf_mem_req_t     mem_req;
	logic [bbsf_pkg::BYTE_W-1:0] mem_rdata;

	// register decode: word index is paddr[2]
	assign cap_sel = (paddr[2] == bbsf_pkg::REG_CAPACITY);
	assign pready  = 1'b1;
	assign prdata  = cap_sel ? bbsf_pkg::APB_DW'(capacity_q) : '0;

	// capacity register, written on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bbsf_pkg::CAPACITY_RST;
		end else if (psel && penable && pwrite && pready && cap_sel) begin
			capacity_q <= pwdata[bbsf_pkg::CNT_W-1:0];
		end
	end

	bbsf_ram #(
		.WIDTH (bbsf_pkg::BYTE_W),
		.DEPTH (bbsf_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	bbsf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.capacity     (capacity_q),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire
